FILE: hw/rtl/rnpc_pkg.sv
// ----------------------------------------------------------------------------
// Ratio nearest profile classifier package
// Shared widths, register layout and reset calibration table.
// ----------------------------------------------------------------------------
package rnpc_pkg;

   // Field widths
   localparam int unsigned CNT_W    = 16;
   localparam int unsigned IDX_W    = 3;
   localparam int unsigned PROF_W   = 64;
   localparam int unsigned SQ_W     = 2 * CNT_W;
   localparam int unsigned SUM_W    = SQ_W + 2;
   localparam int unsigned ROOT_W   = SUM_W + 1;

   // Profile table
   localparam int unsigned REG_COUNT        = 5;
   localparam int unsigned TABLE_MAX        = 8;
   localparam int unsigned NUM_PROFILES_DEF = 5;
   localparam int unsigned NUM_CH           = 3;

   // Pipeline depth of the two iterative units
   localparam int unsigned DIV_STEPS  = CNT_W;
   localparam int unsigned ROOT_STEPS = 17;

   // Configuration port
   localparam int unsigned CSR_AW = 6;

   typedef logic [CNT_W-1:0]  word_type;
   typedef logic [PROF_W-1:0] prof_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [ROOT_W-1:0] root_type;

   localparam prof_type PROFILE_RESET [REG_COUNT] = '{
      64'd31031757179437,
      64'd36057226076425257,
      64'd72080113259056923,
      64'd144132780977033773,
      64'd360297471354149126
   };

   // Norm of one channel in a packed profile: channel 0 in 47:32, 1 in 31:16, 2 in 15:0
   function automatic word_type prof_norm(input prof_type p, input int unsigned ch);
      word_type n;
      n = p[CNT_W*(NUM_CH-1-ch) +: CNT_W];
      return n;
   endfunction

endpackage

FILE: hw/rtl/ratio_nearest_profile_classifier.sv
// ----------------------------------------------------------------------------
// Ratio nearest profile classifier
// Normalizes three channel counts by the clear count, picks the nearest stored
// profile and reports its concentration, index and distance.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the result side keeps up. The pipeline
// is the divider (a load stage and 16 bit-per-stage stages), three stages of
// difference, square and sum, one compare stage per profile, the square root
// (a load stage and 17 bit-per-stage stages) and the output register.
// The whole pipeline holds while the output register is full and not taken.
// Profiles are 64-bit registers at byte address 8*i; write them only while the
// pipeline is empty.
module ratio_nearest_profile_classifier #(
   parameter int unsigned NUM_PROFILES = rnpc_pkg::NUM_PROFILES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request: green[15:0], orange[31:16], red[47:32], clear[63:48]
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [63:0]                req_tdata,
   // response: concentration[15:0], match_index[18:16], distance[34:19]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [39:0]                rsp_tdata,
   // response user: clear_zero_error[0]
   output logic [0:0]                 rsp_tuser,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [rnpc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [63:0]                csr_pwdata,
   output logic [63:0]                csr_prdata,
   output logic                       csr_pready
);
   import rnpc_pkg::*;

   localparam int unsigned NP = NUM_PROFILES;
   localparam int unsigned DS = DIV_STEPS;
   localparam int unsigned RS = ROOT_STEPS;

   // ---------------------------------------------------------------- registers
   prof_type profile_ff [REG_COUNT];
   prof_type tbl [TABLE_MAX];
   logic [IDX_W-1:0] csr_idx;
   logic en;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < REG_COUNT; r++) profile_ff[r] <= PROFILE_RESET[r];
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   ({29'd0, csr_idx} < REG_COUNT)) begin
         profile_ff[csr_idx] <= csr_pwdata;
      end
   end

   // Entries without a register read as zero
   for (genvar t = 0; t < TABLE_MAX; t++) begin : g_tbl
      if (t < REG_COUNT) begin : g_reg
         assign tbl[t] = profile_ff[t];
      end else begin : g_zero
         assign tbl[t] = '0;
      end
   end

   assign csr_prdata = tbl[csr_idx];

   // Advance the whole pipeline unless the output register is held
   logic rsp_tvalid_ff;
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // ---------------------------------------------------------------- divider
   logic [DS:0]     dv_ff, dv_in;
   logic            dz_ff   [DS+1];
   logic            dz_in   [DS+1];
   word_type        dclr_ff [DS+1];
   word_type        dclr_in [DS+1];
   logic [CNT_W:0]  drem_ff [DS+1][NUM_CH];
   logic [CNT_W:0]  drem_in [DS+1][NUM_CH];
   word_type        dq_ff   [DS+1][NUM_CH];
   word_type        dq_in   [DS+1][NUM_CH];
   logic [1:0]      dlo_ff  [DS+1][NUM_CH];
   logic [1:0]      dlo_in  [DS+1][NUM_CH];
   logic            dsat_ff [DS+1][NUM_CH];
   logic            dsat_in [DS+1][NUM_CH];

   always_comb begin
      word_type cnt;
      word_type clr;
      logic [CNT_W:0] sh;
      logic nbit;
      logic ge;
      // Load: quotient fits 16 bits unless count >= 4 * clear
      clr        = req_tdata[63:48];
      dv_in[0]   = req_tvalid;
      dz_in[0]   = (clr == '0);
      dclr_in[0] = clr;
      for (int c = 0; c < NUM_CH; c++) begin
         cnt           = req_tdata[CNT_W*c +: CNT_W];
         drem_in[0][c] = {3'd0, cnt[CNT_W-1:2]};
         dq_in[0][c]   = '0;
         dlo_in[0][c]  = cnt[1:0];
         dsat_in[0][c] = ({2'b00, cnt} >= {clr, 2'b00});
      end
      // One quotient bit per stage
      for (int k = 0; k < DS; k++) begin
         dv_in[k+1]   = dv_ff[k];
         dz_in[k+1]   = dz_ff[k];
         dclr_in[k+1] = dclr_ff[k];
         for (int c = 0; c < NUM_CH; c++) begin
            nbit = (k == 0) ? dlo_ff[k][c][1] : ((k == 1) ? dlo_ff[k][c][0] : 1'b0);
            sh   = {drem_ff[k][c][CNT_W-1:0], nbit};
            ge   = (sh >= {1'b0, dclr_ff[k]});
            drem_in[k+1][c]        = ge ? (sh - {1'b0, dclr_ff[k]}) : sh;
            dq_in[k+1][c]          = dq_ff[k][c];
            dq_in[k+1][c][DS-1-k]  = ge;
            dlo_in[k+1][c]         = dlo_ff[k][c];
            dsat_in[k+1][c]        = dsat_ff[k][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (en) begin
         dv_ff <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dz_ff   <= dz_in;
         dclr_ff <= dclr_in;
         drem_ff <= drem_in;
         dq_ff   <= dq_in;
         dlo_ff  <= dlo_in;
         dsat_ff <= dsat_in;
      end
   end

   // ---------------------------------------------------------------- distance
   logic     av_ff, av_in, bv_ff, cv_ff;
   logic     az_ff, az_in, bz_ff, cz_ff;
   word_type ad_ff [NP][NUM_CH];
   word_type ad_in [NP][NUM_CH];
   logic [SQ_W-1:0] sq_ff [NP][NUM_CH];
   sum_type  sum_ff [NP];

   always_comb begin
      word_type r;
      word_type n;
      av_in = dv_ff[DS];
      az_in = dz_ff[DS];
      for (int c = 0; c < NUM_CH; c++) begin
         r = dsat_ff[DS][c] ? '1 : dq_ff[DS][c];
         for (int p = 0; p < NP; p++) begin
            n = prof_norm(tbl[p], c);
            ad_in[p][c] = (r >= n) ? (r - n) : (n - r);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
         bv_ff <= 1'b0;
         cv_ff <= 1'b0;
      end else if (en) begin
         av_ff <= av_in;
         bv_ff <= av_ff;
         cv_ff <= bv_ff;
      end
   end

   // Difference, square, sum
   always_ff @(posedge clock) begin
      if (en) begin
         az_ff <= az_in;
         bz_ff <= az_ff;
         cz_ff <= bz_ff;
         ad_ff <= ad_in;
         for (int p = 0; p < NP; p++) begin
            for (int c = 0; c < NUM_CH; c++) sq_ff[p][c] <= ad_ff[p][c] * ad_ff[p][c];
            sum_ff[p] <= {2'b00, sq_ff[p][0]} + {2'b00, sq_ff[p][1]} +
                         {2'b00, sq_ff[p][2]};
         end
      end
   end

   // ---------------------------------------------------------------- minimum
   logic [NP-1:0]    mv_ff, mv_in;
   logic             mz_ff   [NP];
   logic             mz_in   [NP];
   sum_type          msum_ff [NP][NP];
   sum_type          msum_in [NP][NP];
   sum_type          mbest_ff [NP];
   sum_type          mbest_in [NP];
   logic [IDX_W-1:0] midx_ff  [NP];
   logic [IDX_W-1:0] midx_in  [NP];

   always_comb begin
      logic lt;
      mv_in[0]    = cv_ff;
      mz_in[0]    = cz_ff;
      msum_in[0]  = sum_ff;
      mbest_in[0] = sum_ff[0];
      midx_in[0]  = '0;
      // One profile compared per stage; strict less keeps the first on ties
      for (int j = 1; j < NP; j++) begin
         lt          = (msum_ff[j-1][j] < mbest_ff[j-1]);
         mv_in[j]    = mv_ff[j-1];
         mz_in[j]    = mz_ff[j-1];
         msum_in[j]  = msum_ff[j-1];
         mbest_in[j] = lt ? msum_ff[j-1][j] : mbest_ff[j-1];
         midx_in[j]  = lt ? IDX_W'(j) : midx_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= '0;
      end else if (en) begin
         mv_ff <= mv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mz_ff    <= mz_in;
         msum_ff  <= msum_in;
         mbest_ff <= mbest_in;
         midx_ff  <= midx_in;
      end
   end

   // ---------------------------------------------------------------- square root
   logic [RS:0]      qv_ff, qv_in;
   logic             qz_ff   [RS+1];
   logic             qz_in   [RS+1];
   root_type         qrem_ff [RS+1];
   root_type         qrem_in [RS+1];
   root_type         qres_ff [RS+1];
   root_type         qres_in [RS+1];
   logic [IDX_W-1:0] qidx_ff [RS+1];
   logic [IDX_W-1:0] qidx_in [RS+1];

   always_comb begin
      root_type bitv;
      root_type trial;
      qv_in[0]   = mv_ff[NP-1];
      qz_in[0]   = mz_ff[NP-1];
      qrem_in[0] = {1'b0, mbest_ff[NP-1]};
      qres_in[0] = '0;
      qidx_in[0] = midx_ff[NP-1];
      // One root bit per stage, from bit 16 down
      for (int k = 0; k < RS; k++) begin
         bitv  = root_type'(1) << (2 * (RS - 1 - k));
         trial = qres_ff[k] + bitv;
         qv_in[k+1]   = qv_ff[k];
         qz_in[k+1]   = qz_ff[k];
         qidx_in[k+1] = qidx_ff[k];
         if (qrem_ff[k] >= trial) begin
            qrem_in[k+1] = qrem_ff[k] - trial;
            qres_in[k+1] = (qres_ff[k] >> 1) + bitv;
         end else begin
            qrem_in[k+1] = qrem_ff[k];
            qres_in[k+1] = qres_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= '0;
      end else if (en) begin
         qv_ff <= qv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qz_ff   <= qz_in;
         qrem_ff <= qrem_in;
         qres_ff <= qres_in;
         qidx_ff <= qidx_in;
      end
   end

   // ---------------------------------------------------------------- output
   word_type         conc_ff, conc_in;
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   word_type         dist_ff, dist_in;
   logic             err_ff;

   always_comb begin
      root_type res;
      res = qres_ff[RS];
      if (qz_ff[RS]) begin
         conc_in = '0;
         oidx_in = '0;
         dist_in = '0;
      end else begin
         conc_in = tbl[qidx_ff[RS]][PROF_W-1 -: CNT_W];
         oidx_in = qidx_ff[RS];
         dist_in = (res > root_type'(16'hFFFF)) ? '1 : res[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= qv_ff[RS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         conc_ff <= conc_in;
         oidx_ff <= oidx_in;
         dist_ff <= dist_in;
         err_ff  <= qz_ff[RS];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'd0, dist_ff, oidx_ff, conc_ff};
   assign rsp_tuser  = err_ff;

endmodule
